// ===== design/scm_pkg.sv =====
// shared types, codes and widths for the solver convergence monitor
`default_nettype none
package scm_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;

   // shared subtract/compare unit width: a 33-bit sqrt remainder plus two input bits
   localparam int ALU_W = 35;

   localparam logic [31:0] MAX32   = 32'hFFFF_FFFF;
   localparam logic [23:0] MAX24   = 24'hFF_FFFF;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   localparam logic OP_START  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic [1:0] MODE_ABSOLUTE = 2'd0;
   localparam logic [1:0] MODE_RELATIVE = 2'd1;

   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_STAGNATION = 2'd1;
   localparam logic [1:0] ERR_ITER_LIMIT = 2'd2;
   localparam logic [1:0] ERR_INVALID    = 2'd3;

   localparam logic [1:0] CSR_PRECISION      = 2'd0;
   localparam logic [1:0] CSR_CRITERION_MODE = 2'd1;
   localparam logic [1:0] CSR_STAG_WINDOW    = 2'd2;
   localparam logic [1:0] CSR_ITER_LIMIT     = 2'd3;

   localparam logic [31:0] PRECISION_RST = 32'd66;
   localparam logic [1:0]  MODE_RST      = 2'd0;
   localparam logic [4:0]  WINDOW_RST    = 5'd10;
   localparam logic [23:0] LIMIT_RST     = 24'd200;

   typedef struct packed {
      logic wr_en;
      logic wr_bad;
      logic rd_en;
   } hist_ctrl_type;

endpackage
`default_nettype wire

// ===== design/scm_alu.sv =====
// shared subtract/compare unit used by the square root, divide, compare and pointer-wrap steps
`default_nettype none
module scm_alu (
   input  wire logic [scm_pkg::ALU_W-1:0] op_a,
   input  wire logic [scm_pkg::ALU_W-1:0] op_b,
   output logic      [scm_pkg::ALU_W-1:0] diff,
   output logic                           a_ge_b
);
   import scm_pkg::*;

   logic [ALU_W:0] sub_full;

   assign sub_full = {1'b0, op_a} - {1'b0, op_b};
   assign diff     = sub_full[ALU_W-1:0];
   assign a_ge_b   = ~sub_full[ALU_W];

endmodule
`default_nettype wire

// ===== design/scm_history.sv =====
// criterion history ring: memory with registered read plus per-entry written and invalid marks
`default_nettype none
module scm_history #(
   parameter int HISTORY_DEPTH = scm_pkg::HISTORY_DEPTH_DEF,
   parameter int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire scm_pkg::hist_ctrl_type ctrl,
   input  wire logic [PW-1:0]         wr_addr,
   input  wire logic [31:0]           wr_data,
   input  wire logic [PW-1:0]         rd_addr,
   output logic      [31:0]           rd_value,
   output logic                       rd_bad
);
   import scm_pkg::*;

   logic [31:0]              mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] written_ff;
   logic [HISTORY_DEPTH-1:0] bad_ff;
   logic [31:0]              rd_data_ff;
   logic                     rd_hit_ff;
   logic                     rd_bad_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         bad_ff     <= '0;
         rd_hit_ff  <= 1'b0;
         rd_bad_ff  <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            written_ff[wr_addr] <= 1'b1;
            bad_ff[wr_addr]     <= ctrl.wr_bad;
         end
         if (ctrl.rd_en) begin
            rd_hit_ff <= written_ff[rd_addr];
            rd_bad_ff <= bad_ff[rd_addr];
         end
      end
   end

   // never-written entries read as the reset value of zero
   assign rd_value = rd_hit_ff ? rd_data_ff : 32'd0;
   assign rd_bad   = rd_bad_ff;

endmodule
`default_nettype wire

// ===== design/solver_convergence_monitor.sv =====
// Solver convergence monitor: residual norm, relative norm, stopping and error decision per item.
// Each transfer on req_ takes the squared residual norm (unsigned Q32.32) and yields one
// transfer on rsp_ with the Q16.16 absolute and relative norms, the stop flag, the sticky
// error code and the iteration count. One item is worked at a time through a single shared
// 35-bit subtract/compare unit: a 32-step digit-recurrence square root, then on updates a
// saturation check and a 32-step restoring divide, then a few compare steps.
// A start fills W history entries, one per cycle (W the effective stagnation window). An update
// skips the divide when the quotient saturates, and wraps the history pointer with one window
// subtraction per step (normally none or one, at most HISTORY_DEPTH after the window shrinks).
// A finished result may also wait for rsp_ready before it is loaded into the output register.
// req_ready is high only while idle; a finished result waits in the output register.
`default_nettype none
module solver_convergence_monitor #(
   parameter int HISTORY_DEPTH = scm_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [63:0] req_squared_norm,
   input  wire logic        req_norm_invalid,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_absolute_norm,
   output logic      [31:0] rsp_relative_norm,
   output logic             rsp_converged,
   output logic      [1:0]  rsp_error_code,
   output logic      [23:0] rsp_iteration_count,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import scm_pkg::*;

   localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int NW = PW + 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQRT  = 4'd1;
   localparam logic [3:0] ST_DCHK  = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_PREC  = 4'd4;
   localparam logic [3:0] ST_FILL  = 4'd5;
   localparam logic [3:0] ST_WRITE = 4'd6;
   localparam logic [3:0] ST_MOD   = 4'd7;
   localparam logic [3:0] ST_READ  = 4'd8;
   localparam logic [3:0] ST_CHECK = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   // configuration
   logic [31:0] precision_ff;
   logic [1:0]  mode_ff;
   logic [4:0]  window_ff;
   logic [23:0] limit_ff;

   // control
   logic [3:0]    state_ff, state_in;
   logic [4:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   counter_ff, counter_in;
   logic [1:0]    err_ff, err_in;
   logic [31:0]   init_ff, init_in;
   logic [PW-1:0] ptr_ff, ptr_in;

   // datapath
   logic          op_ff, op_in;
   logic          inv_ff, inv_in;
   logic [63:0]   sq_ff, sq_in;
   logic [ALU_W-1:0] rem_ff, rem_in;
   logic [31:0]   root_ff, root_in;
   logic [31:0]   quo_ff, quo_in;
   logic [31:0]   absn_ff, absn_in;
   logic [31:0]   reln_ff, reln_in;
   logic          conv_ff, conv_in;
   logic [NW-1:0] nxt_ff, nxt_in;

   // result register
   logic [31:0] out_abs_ff, out_rel_ff;
   logic        out_conv_ff;
   logic [1:0]  out_err_ff;
   logic [23:0] out_cnt_ff;
   logic        load_out;

   logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic             alu_ge;

   hist_ctrl_type hctrl;
   logic [PW-1:0] h_wr_addr;
   logic [31:0]   h_rd_value;
   logic          h_rd_bad;

   logic [31:0]   win_ext;
   logic [NW-1:0] w_eff;
   logic [31:0]   crit;
   logic          stag;
   logic          c_tmp;
   logic [1:0]    e_tmp;

   scm_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .diff   (alu_diff),
      .a_ge_b (alu_ge)
   );

   scm_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .PW            (PW)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (hctrl),
      .wr_addr  (h_wr_addr),
      .wr_data  (crit),
      .rd_addr  (nxt_ff[PW-1:0]),
      .rd_value (h_rd_value),
      .rd_bad   (h_rd_bad)
   );

   // effective window: zero counts as one, clipped at the history depth
   assign win_ext = {27'd0, window_ff};
   always_comb begin
      priority if (win_ext == 32'd0) begin
         w_eff = NW'(1);
      end else if (win_ext > 32'(HISTORY_DEPTH)) begin
         w_eff = NW'(HISTORY_DEPTH);
      end else begin
         w_eff = NW'(win_ext);
      end
   end

   always_comb begin
      priority if (mode_ff == MODE_ABSOLUTE) begin
         crit = absn_ff;
      end else if (mode_ff == MODE_RELATIVE) begin
         crit = reln_ff;
      end else begin
         crit = MAX32;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_absolute_norm   = out_abs_ff;
   assign rsp_relative_norm   = out_rel_ff;
   assign rsp_converged       = out_conv_ff;
   assign rsp_error_code      = out_err_ff;
   assign rsp_iteration_count = out_cnt_ff;

   // shared unit operand selection
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_SQRT: begin
            alu_a = {rem_ff[ALU_W-3:0], sq_ff[63:62]};
            alu_b = ALU_W'({root_ff, 2'b01});
         end
         ST_DCHK: begin
            alu_a = ALU_W'(absn_ff[31:16]);
            alu_b = ALU_W'(init_ff);
         end
         ST_DIV: begin
            alu_a = ALU_W'({rem_ff[31:0], sq_ff[63]});
            alu_b = ALU_W'(init_ff);
         end
         ST_PREC: begin
            alu_a = ALU_W'((op_ff == OP_START) ? absn_ff : crit);
            alu_b = ALU_W'(precision_ff);
         end
         ST_MOD: begin
            alu_a = ALU_W'(nxt_ff);
            alu_b = ALU_W'(w_eff);
         end
         ST_CHECK: begin
            alu_a = ALU_W'(h_rd_value);
            alu_b = ALU_W'(crit);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // update-step decision, in priority order: invalid data, stagnation, iteration limit
   always_comb begin
      stag  = !alu_ge && (ALU_W'(w_eff) <= ALU_W'(counter_ff)) && !inv_ff && !h_rd_bad;
      c_tmp = conv_ff;
      e_tmp = err_ff;
      if (stag) begin
         e_tmp = ERR_STAGNATION;
         c_tmp = 1'b1;
      end
      if ((counter_ff == limit_ff) && !c_tmp) begin
         e_tmp = ERR_ITER_LIMIT;
         c_tmp = 1'b1;
      end
      if (inv_ff) begin
         e_tmp = ERR_INVALID;
         c_tmp = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      counter_in = counter_ff;
      err_in     = err_ff;
      init_in    = init_ff;
      ptr_in     = ptr_ff;
      op_in      = op_ff;
      inv_in     = inv_ff;
      sq_in      = sq_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      quo_in     = quo_ff;
      absn_in    = absn_ff;
      reln_in    = reln_ff;
      conv_in    = conv_ff;
      nxt_in     = nxt_ff;
      load_out   = 1'b0;
      hctrl      = '0;
      h_wr_addr  = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               inv_in   = req_norm_invalid;
               sq_in    = req_squared_norm;
               rem_in   = '0;
               root_in  = '0;
               step_in  = 5'd31;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = alu_ge ? alu_diff : alu_a;
            root_in = {root_ff[30:0], alu_ge};
            sq_in   = {sq_ff[61:0], 2'b00};
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               absn_in = {root_ff[30:0], alu_ge};
               if (op_ff == OP_START) begin
                  reln_in  = ONE_Q16;
                  state_in = ST_PREC;
               end else begin
                  state_in = ST_DCHK;
               end
            end
         end
         ST_DCHK: begin
            // quotient overflows 32 bits (or divisor is zero) when abs[31:16] >= initial
            if (alu_ge) begin
               reln_in  = MAX32;
               state_in = ST_PREC;
            end else begin
               rem_in   = ALU_W'(absn_ff[31:16]);
               sq_in    = {absn_ff[15:0], 48'd0};
               step_in  = 5'd31;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = alu_ge ? alu_diff : alu_a;
            quo_in  = {quo_ff[30:0], alu_ge};
            sq_in   = {sq_ff[62:0], 1'b0};
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               reln_in  = {quo_ff[30:0], alu_ge};
               state_in = ST_PREC;
            end
         end
         ST_PREC: begin
            if (op_ff == OP_START) begin
               conv_in    = !alu_ge;
               counter_in = 24'd1;
               init_in    = absn_ff;
               err_in     = ERR_NONE;
               ptr_in     = '0;
               nxt_in     = '0;
               state_in   = ST_FILL;
            end else begin
               conv_in  = !alu_ge && !inv_ff;
               state_in = ST_WRITE;
            end
         end
         ST_FILL: begin
            hctrl.wr_en  = 1'b1;
            hctrl.wr_bad = 1'b0;
            h_wr_addr    = nxt_ff[PW-1:0];
            nxt_in       = nxt_ff + NW'(1);
            if ((nxt_ff + NW'(1)) == w_eff) begin
               state_in = ST_OUT;
            end
         end
         ST_WRITE: begin
            hctrl.wr_en  = 1'b1;
            hctrl.wr_bad = inv_ff;
            h_wr_addr    = ptr_ff;
            nxt_in       = {1'b0, ptr_ff} + NW'(1);
            state_in     = ST_MOD;
         end
         ST_MOD: begin
            // wrap the pointer by repeated window subtraction
            if (alu_ge) begin
               nxt_in = alu_diff[NW-1:0];
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            hctrl.rd_en = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            ptr_in  = nxt_ff[PW-1:0];
            conv_in = c_tmp;
            err_in  = e_tmp;
            if (!c_tmp && (counter_ff < MAX24)) begin
               counter_in = counter_ff + 24'd1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
         err_ff       <= ERR_NONE;
         init_ff      <= '0;
         ptr_ff       <= '0;
         precision_ff <= PRECISION_RST;
         mode_ff      <= MODE_RST;
         window_ff    <= WINDOW_RST;
         limit_ff     <= LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
         err_ff       <= err_in;
         init_ff      <= init_in;
         ptr_ff       <= ptr_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PRECISION:      precision_ff <= csr_write_data;
               CSR_CRITERION_MODE: mode_ff      <= csr_write_data[1:0];
               CSR_STAG_WINDOW:    window_ff    <= csr_write_data[4:0];
               CSR_ITER_LIMIT:     limit_ff     <= csr_write_data[23:0];
               default:            limit_ff     <= limit_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      inv_ff  <= inv_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      quo_ff  <= quo_in;
      absn_ff <= absn_in;
      reln_ff <= reln_in;
      conv_ff <= conv_in;
      nxt_ff  <= nxt_in;
      if (load_out) begin
         out_abs_ff  <= absn_ff;
         out_rel_ff  <= reln_ff;
         out_conv_ff <= conv_ff;
         out_err_ff  <= err_ff;
         out_cnt_ff  <= counter_ff;
      end
   end

endmodule
`default_nettype wire
